### rtl/htmr_pkg.sv
// Shared types, widths and reset values for the hall tachometer and motor ramp block.
`default_nettype none

package htmr_pkg;

  // Default values of the top-level parameters
  localparam int unsigned FILTER_DEPTH_DEF = 8;
  localparam int unsigned SAMPLE_BITS_DEF  = 12;

  // Fixed field widths
  localparam int unsigned CMD_W      = 3;
  localparam int unsigned THR_W      = 12;
  localparam int unsigned PULSE_W    = 12;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned OMEGA_W    = 32;
  localparam int unsigned NUM_W      = 40;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_ADDR_W = 6;
  localparam int unsigned CFG_IDX_W  = 3;

  // Configuration reset values
  localparam logic [THR_W-1:0]   ENTRY_THR_RST = 12'hFEC;   // -20
  localparam logic [THR_W-1:0]   EXIT_THR_RST  = 12'd20;
  localparam logic [PULSE_W-1:0] STOP_PULSE_RST  = 12'd1000;
  localparam logic [PULSE_W-1:0] START_PULSE_RST = 12'd1100;
  localparam logic [PULSE_W-1:0] MAX_PULSE_RST   = 12'd2000;
  localparam logic [TIME_W-1:0]  RAMP_INTERVAL_RST = 32'd20000;
  localparam logic [NUM_W-1:0]   OMEGA_NUM_RST     = 40'd379000000000;

  localparam logic [OMEGA_W-1:0] OMEGA_SAT = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE = 3'd0,
    CMD_START  = 3'd1,
    CMD_STOP   = 3'd2,
    CMD_TARGET = 3'd3,
    CMD_FORCE  = 3'd4
  } cmd_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_STOPPED  = 2'd0,
    MODE_STARTING = 2'd1,
    MODE_SPINNING = 2'd2,
    MODE_STOPPING = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENTRY_THR     = 3'd0,
    REG_EXIT_THR      = 3'd1,
    REG_STOP_PULSE    = 3'd2,
    REG_START_PULSE   = 3'd3,
    REG_MAX_PULSE     = 3'd4,
    REG_RAMP_INTERVAL = 3'd5,
    REG_OMEGA_NUM     = 3'd6
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_SCALE,
    ST_DECIDE,
    ST_DIVIDE,
    ST_EMIT
  } seq_state_t;

  // Divider request: quotient of {num_hi, num_lo} / den, num_hi < den
  typedef struct packed {
    logic               start;
    logic [OMEGA_W-1:0] num_hi;
    logic [OMEGA_W-1:0] num_lo;
    logic [TIME_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [OMEGA_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

### rtl/hall_tachometer_motor_ramp.sv
// Hall tachometer with moving-average filter, marker rate measurement and soft-start ramp.
// Sequence: a command item goes from IDLE to EMIT; a sample item passes SUM, SCALE, DECIDE,
//   and DIVIDE when it enters the marker and the rate goes through the 32-step divider.
// Flow: one item at a time; a new item is taken only in IDLE, which EMIT reaches once the
//   output is free, so an output stall holds the next item. A new item is taken while an
//   earlier result still sits in the output register.
// Reset (rst, synchronous): sequencer idle, config to defaults, ring valid bits cleared so the
//   whole ring reads as zero; no clearing pass, items are taken right after reset.
`default_nettype none

module hall_tachometer_motor_ramp #(
  parameter int unsigned FILTER_DEPTH = htmr_pkg::FILTER_DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS  = htmr_pkg::SAMPLE_BITS_DEF,
  localparam int unsigned IN_W  = ((SAMPLE_BITS + htmr_pkg::TIME_W + htmr_pkg::PULSE_W
                                    + htmr_pkg::MODE_W + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((htmr_pkg::PULSE_W + htmr_pkg::MODE_W + 1
                                    + htmr_pkg::OMEGA_W + SAMPLE_BITS + 7) / 8) * 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // input item stream
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // hall_sample, now_us, target_pulse, new_state (from bit 0 up)
  input  wire logic [IN_W-1:0]                  s_tdata,
  // cmd
  input  wire logic [htmr_pkg::CMD_W-1:0]       s_tuser,
  // result item stream
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // motor_pulse, spin_state, trigger_pulse, omega_q16, filtered_level (from bit 0 up)
  output logic [OUT_W-1:0]                      m_tdata,
  // omega_new
  output logic [0:0]                            m_tuser,
  // configuration port
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [htmr_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [htmr_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [htmr_pkg::CFG_DATA_W-1:0]       prdata,
  output logic                                  pready
);
  import htmr_pkg::*;

  // Filter arithmetic: ring sum, its magnitude and a reciprocal multiply for / FILTER_DEPTH.
  // RECIP = ceil(2^SHIFT / depth) gives the exact floor for every magnitude below 2^MAG_W.
  localparam int unsigned POS_W  = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
  localparam int unsigned LOG_D  = $clog2(FILTER_DEPTH);
  localparam int unsigned SUM_W  = SAMPLE_BITS + LOG_D;
  localparam int unsigned MAG_W  = SUM_W;
  localparam int unsigned SHIFT  = MAG_W + LOG_D;
  localparam int unsigned REC_W  = MAG_W + 1;
  localparam int unsigned PROD_W = MAG_W + REC_W;
  localparam logic [63:0] RECIP  = ((64'd1 << SHIFT) + 64'(FILTER_DEPTH) - 64'd1)
                                   / 64'(FILTER_DEPTH);
  localparam int unsigned CMP_W  = ((SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W) + 1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [THR_W-1:0]   entry_thr;
  logic [THR_W-1:0]   exit_thr;
  logic [PULSE_W-1:0] stop_pulse;
  logic [PULSE_W-1:0] start_pulse;
  logic [PULSE_W-1:0] max_pulse;
  logic [TIME_W-1:0]  ramp_interval;
  logic [NUM_W-1:0]   omega_num;

  logic     cfg_write;
  cfg_reg_t cfg_idx;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_idx   = cfg_reg_t'(paddr[CFG_ADDR_W-1:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_thr     <= ENTRY_THR_RST;
      exit_thr      <= EXIT_THR_RST;
      stop_pulse    <= STOP_PULSE_RST;
      start_pulse   <= START_PULSE_RST;
      max_pulse     <= MAX_PULSE_RST;
      ramp_interval <= RAMP_INTERVAL_RST;
      omega_num     <= OMEGA_NUM_RST;
    end else if (cfg_write) begin
      case (cfg_idx)
        REG_ENTRY_THR:     entry_thr     <= pwdata[THR_W-1:0];
        REG_EXIT_THR:      exit_thr      <= pwdata[THR_W-1:0];
        REG_STOP_PULSE:    stop_pulse    <= pwdata[PULSE_W-1:0];
        REG_START_PULSE:   start_pulse   <= pwdata[PULSE_W-1:0];
        REG_MAX_PULSE:     max_pulse     <= pwdata[PULSE_W-1:0];
        REG_RAMP_INTERVAL: ramp_interval <= pwdata[TIME_W-1:0];
        REG_OMEGA_NUM:     omega_num     <= pwdata[NUM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ENTRY_THR:     prdata = CFG_DATA_W'(entry_thr);
      REG_EXIT_THR:      prdata = CFG_DATA_W'(exit_thr);
      REG_STOP_PULSE:    prdata = CFG_DATA_W'(stop_pulse);
      REG_START_PULSE:   prdata = CFG_DATA_W'(start_pulse);
      REG_MAX_PULSE:     prdata = CFG_DATA_W'(max_pulse);
      REG_RAMP_INTERVAL: prdata = CFG_DATA_W'(ramp_interval);
      REG_OMEGA_NUM:     prdata = CFG_DATA_W'(omega_num);
      default:           prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input unpacking
  // ---------------------------------------------------------------------------
  logic [SAMPLE_BITS-1:0] in_sample;
  logic [TIME_W-1:0]      in_now;
  logic [PULSE_W-1:0]     in_target;
  logic [MODE_W-1:0]      in_new_state;
  cmd_t                   in_cmd;

  assign in_sample    = s_tdata[SAMPLE_BITS-1:0];
  assign in_now       = s_tdata[SAMPLE_BITS +: TIME_W];
  assign in_target    = s_tdata[SAMPLE_BITS + TIME_W +: PULSE_W];
  assign in_new_state = s_tdata[SAMPLE_BITS + TIME_W + PULSE_W +: MODE_W];
  assign in_cmd       = cmd_t'(s_tuser);

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  seq_state_t state;
  seq_state_t state_next;

  logic accept;
  logic out_free;
  logic rd_en;
  logic out_load;
  logic div_start;
  logic dec_entry;
  logic dec_sat;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (s_tvalid) begin
                   state_next = (in_cmd == CMD_SAMPLE) ? ST_SUM : ST_EMIT;
                 end
      ST_SUM:    state_next = ST_SCALE;
      ST_SCALE:  state_next = ST_DECIDE;
      ST_DECIDE: state_next = (dec_entry && !dec_sat) ? ST_DIVIDE : ST_EMIT;
      ST_DIVIDE: if (div_rsp.done) begin
                   state_next = ST_EMIT;
                 end
      ST_EMIT:   if (out_free) begin
                   state_next = ST_IDLE;
                 end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = (state == ST_IDLE);
    rd_en     = (state == ST_IDLE) && s_tvalid;
    div_start = (state == ST_DECIDE) && dec_entry && !dec_sat;
    out_load  = (state == ST_EMIT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Sample ring: synchronous memory, one read per item and one write per sample item.
  // Entries never written read as zero through the valid bits.
  // ---------------------------------------------------------------------------
  logic [SAMPLE_BITS-1:0] ring_mem [FILTER_DEPTH];
  logic [SAMPLE_BITS-1:0] ring_rd;
  logic [FILTER_DEPTH-1:0] ring_valid;
  logic [POS_W-1:0]       ring_pos;
  logic signed [SUM_W-1:0] ring_sum;
  logic signed [SUM_W-1:0] ring_sum_next;
  logic signed [SAMPLE_BITS-1:0] old_s;
  logic signed [SAMPLE_BITS-1:0] new_s;

  // item latches
  logic [SAMPLE_BITS-1:0] sample_r;
  logic [TIME_W-1:0]      now_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      ring_rd <= ring_mem[ring_pos];
    end
    if (state == ST_SUM) begin
      ring_mem[ring_pos] <= sample_r;
    end
  end

  assign old_s = ring_valid[ring_pos] ? $signed(ring_rd) : '0;
  assign new_s = $signed(sample_r);
  assign ring_sum_next = ring_sum + SUM_W'(new_s) - SUM_W'(old_s);

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_valid <= '0;
      ring_pos   <= '0;
      ring_sum   <= '0;
    end else if (state == ST_SUM) begin
      ring_valid[ring_pos] <= 1'b1;
      ring_sum             <= ring_sum_next;
      ring_pos <= (ring_pos == POS_W'(FILTER_DEPTH - 1)) ? '0 : ring_pos + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_r <= in_sample;
      now_r    <= in_now;
    end
  end

  // Average: magnitude times reciprocal, registered, then sign restored
  logic [MAG_W-1:0]       sum_mag;
  logic [PROD_W-1:0]      prod;
  logic                   prod_neg;
  logic [SAMPLE_BITS-1:0] lvl_mag;
  logic [SAMPLE_BITS-1:0] lvl_calc;

  assign sum_mag = ring_sum[SUM_W-1] ? MAG_W'(-ring_sum) : MAG_W'(ring_sum);

  always_ff @(posedge clk) begin
    if (state == ST_SCALE) begin
      prod     <= PROD_W'(sum_mag) * PROD_W'(RECIP[REC_W-1:0]);
      prod_neg <= ring_sum[SUM_W-1];
    end
  end

  assign lvl_mag  = prod[SHIFT +: SAMPLE_BITS];
  assign lvl_calc = prod_neg ? (~lvl_mag + SAMPLE_BITS'(1)) : lvl_mag;

  // ---------------------------------------------------------------------------
  // Marker detection and rate
  // ---------------------------------------------------------------------------
  logic                   inside_marker;
  logic [TIME_W-1:0]      exit_time;
  logic [OMEGA_W-1:0]     omega;
  logic [SAMPLE_BITS-1:0] level;
  logic                   trig_r;
  logic                   fresh_r;

  logic signed [CMP_W-1:0] lvl_x;
  logic signed [CMP_W-1:0] entry_x;
  logic signed [CMP_W-1:0] exit_x;
  logic                    dec_exit;
  logic [TIME_W-1:0]       delay;

  assign lvl_x   = CMP_W'($signed(lvl_calc));
  assign entry_x = CMP_W'($signed(entry_thr));
  assign exit_x  = CMP_W'($signed(exit_thr));
  assign dec_entry = !inside_marker && (lvl_x <= entry_x);
  assign dec_exit  = inside_marker && (lvl_x >= exit_x);
  assign delay     = now_r - exit_time;
  // quotient overflows 32 bits exactly when the top numerator bits reach the delay
  assign dec_sat   = (delay == '0) || (TIME_W'(omega_num[NUM_W-1:OMEGA_W]) >= delay);

  assign div_req.start  = div_start;
  assign div_req.num_hi = OMEGA_W'(omega_num[NUM_W-1:OMEGA_W]);
  assign div_req.num_lo = omega_num[OMEGA_W-1:0];
  assign div_req.den    = delay;

  htmr_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_marker <= 1'b0;
      exit_time     <= '0;
      omega         <= '0;
      level         <= '0;
      trig_r        <= 1'b0;
      fresh_r       <= 1'b0;
    end else begin
      if (accept) begin
        trig_r  <= 1'b0;
        fresh_r <= 1'b0;
      end
      if (state == ST_DECIDE) begin
        level <= lvl_calc;
        if (dec_entry) begin
          inside_marker <= 1'b1;
          fresh_r       <= 1'b1;
          if (dec_sat) begin
            omega <= OMEGA_SAT;
          end
        end else if (dec_exit) begin
          inside_marker <= 1'b0;
          exit_time     <= now_r;
          trig_r        <= 1'b1;
        end
      end
      if (state == ST_DIVIDE && div_rsp.done) begin
        omega <= div_rsp.quotient;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Soft-start controller: runs once per sample item, commands act on acceptance
  // ---------------------------------------------------------------------------
  mode_t              mode;
  logic [PULSE_W-1:0] pulse;
  logic [PULSE_W-1:0] desired;
  logic [TIME_W-1:0]  last_ramp;

  logic               due;
  logic [PULSE_W-1:0] spin_step;
  logic [PULSE_W-1:0] spin_hi;
  logic [PULSE_W-1:0] spin_clamped;

  assign due          = (now_r - last_ramp) > ramp_interval;
  assign spin_step    = (pulse < desired) ? pulse + PULSE_W'(1) : pulse - PULSE_W'(1);
  assign spin_hi      = (spin_step >= max_pulse) ? max_pulse : spin_step;
  // stop_pulse wins when the two limits cross
  assign spin_clamped = (spin_hi <= stop_pulse) ? stop_pulse : spin_hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_STOPPED;
      pulse     <= STOP_PULSE_RST;
      desired   <= STOP_PULSE_RST;
      last_ramp <= '0;
    end else if (accept && in_cmd != CMD_SAMPLE) begin
      case (in_cmd)
        CMD_START:  mode    <= MODE_STARTING;
        CMD_STOP:   mode    <= MODE_STOPPING;
        CMD_TARGET: desired <= in_target;
        CMD_FORCE:  mode    <= mode_t'(in_new_state);
        default: ;
      endcase
    end else if (state == ST_DECIDE) begin
      case (mode)
        MODE_STARTING: begin
          if (pulse >= start_pulse) begin
            mode <= MODE_SPINNING;
          end else if (due) begin
            pulse     <= pulse + PULSE_W'(1);
            last_ramp <= now_r;
          end
        end
        MODE_SPINNING: begin
          if (due && desired != pulse) begin
            pulse     <= spin_clamped;
            last_ramp <= now_r;
          end
        end
        MODE_STOPPING: begin
          if (pulse < start_pulse) begin
            mode <= MODE_STOPPED;
          end else if (due) begin
            if (pulse != '0) begin
              pulse <= pulse - PULSE_W'(1);
            end
            last_ramp <= now_r;
          end
        end
        default: pulse <= stop_pulse;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic [PULSE_W-1:0]     out_pulse;
  logic [MODE_W-1:0]      out_mode;
  logic                   out_trig;
  logic [OMEGA_W-1:0]     out_omega;
  logic                   out_fresh;
  logic [SAMPLE_BITS-1:0] out_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pulse <= pulse;
      out_mode  <= mode;
      out_trig  <= trig_r;
      out_omega <= omega;
      out_fresh <= fresh_r;
      out_level <= level;
    end
  end

  assign m_tdata    = OUT_W'({out_level, out_omega, out_trig, out_mode, out_pulse});
  assign m_tuser[0] = out_fresh;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // divider finishes only while the sequencer waits for it
  assert property (@(posedge clk) disable iff (rst) div_rsp.done |-> state == ST_DIVIDE)
    else $error("divider finished outside the divide wait");

  // one step never both enters and leaves the marker
  assert property (@(posedge clk) disable iff (rst) m_tvalid |-> !(out_trig && out_fresh))
    else $error("trigger and new rate reported in the same item");

  // ring pointer stays inside the ring
  assert property (@(posedge clk) disable iff (rst) ring_pos <= POS_W'(FILTER_DEPTH - 1))
    else $error("ring pointer out of range");

  // divider is started only from a marker entry that did not saturate
  assert property (@(posedge clk) disable iff (rst)
    div_req.start |=> state == ST_DIVIDE && inside_marker && fresh_r)
    else $error("divider started without a marker entry");

endmodule

`default_nettype wire

### rtl/htmr_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none

module htmr_divider (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire htmr_pkg::div_req_t req,
  output htmr_pkg::div_rsp_t      rsp
);
  import htmr_pkg::*;

  localparam int unsigned CNT_W = $clog2(OMEGA_W + 1);

  logic [OMEGA_W-1:0] rem;
  logic [OMEGA_W-1:0] quo;
  logic [TIME_W-1:0]  den;
  logic [CNT_W-1:0]   cnt;
  logic               busy;
  logic               done;

  logic [OMEGA_W:0]   shifted;
  logic [OMEGA_W:0]   diff;

  assign shifted = {rem, quo[OMEGA_W-1]};
  assign diff    = shifted - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(OMEGA_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.num_hi;
      quo <= req.num_lo;
      den <= req.den;
    end else if (busy) begin
      // keep the remainder below the divisor
      if (!diff[OMEGA_W]) begin
        rem <= diff[OMEGA_W-1:0];
        quo <= {quo[OMEGA_W-2:0], 1'b1};
      end else begin
        rem <= shifted[OMEGA_W-1:0];
        quo <= {quo[OMEGA_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

`default_nettype wire
